/* hw/rtl/sbt_pkg.sv */
package sbt_pkg;

	localparam int KW_LEN = 10;
	localparam int POS_BITS = 16;
	localparam int NAME_IDX_BITS = $clog2(KW_LEN);

	localparam logic [5:0] K_END = 6'd15;
	localparam logic [5:0] K_IDENT = 6'd23;
	localparam logic [5:0] K_INTLIT = 6'd26;
	localparam logic [5:0] K_STRLIT = 6'd48;
	localparam logic [5:0] K_NAME_CHAR = 6'd54;
	localparam logic [5:0] K_STR_CHAR = 6'd55;
	localparam logic [5:0] K_ERROR = 6'd56;
	localparam logic [5:0] K_NONE = 6'd63;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_BAD_ESC = 3'd1;
	localparam logic [2:0] E_ESC_EOI = 3'd2;
	localparam logic [2:0] E_UNCLOSED = 3'd3;
	localparam logic [2:0] E_OVERFLOW = 3'd4;
	localparam logic [2:0] E_UNEXPECTED = 3'd5;

	localparam logic [31:0] OVF_LIMIT = 32'd214748364;

	typedef enum logic [2:0] {
		M_IDLE, M_NAME, M_NUM, M_STR, M_ESC, M_OP, M_CMT
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [2:0]  error_code;
	} tok_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_prefix(input logic [7:0] c);
		return c == "=" || c == ">" || c == "<" || c == "!" || c == "+" || c == "-" ||
			c == "*" || c == "/" || c == "&" || c == "|" || c == "^" || c == ":";
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			"+": return 6'd40;
			"-": return 6'd33;
			"*": return 6'd36;
			"/": return 6'd11;
			"%": return 6'd35;
			"&": return 6'd3;
			"|": return 6'd5;
			"^": return 6'd52;
			";": return 6'd46;
			":": return 6'd8;
			"=": return 6'd2;
			"!": return 6'd17;
			"(": return 6'd31;
			")": return 6'd45;
			"[": return 6'd28;
			"]": return 6'd43;
			"<": return 6'd32;
			">": return 6'd22;
			",": return 6'd10;
			"{": return 6'd27;
			"}": return 6'd42;
			".": return 6'd13;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
		logic [5:0] k;
		k = K_NONE;
		if (b == "=") begin
			case (c)
				"=": k = 6'd16;
				">": k = 6'd21;
				"<": k = 6'd29;
				"!": k = 6'd38;
				"+": k = 6'd41;
				"-": k = 6'd34;
				"*": k = 6'd37;
				"/": k = 6'd12;
				"&": k = 6'd4;
				"|": k = 6'd6;
				"^": k = 6'd53;
				default: k = K_NONE;
			endcase
		end else if (c == "-" && b == ">") k = 6'd1;
		else if (c == "&" && b == "&") k = 6'd0;
		else if (c == "|" && b == "|") k = 6'd39;
		else if (c == ":" && b == ":") k = 6'd9;
		return k;
	endfunction

	// Keyword lookup over the stored prefix; unused bytes compare as zero
	function automatic logic [5:0] kw_kind(input logic [KW_LEN*8-1:0] buf_in,
			input logic [15:0] len);
		logic [10*8-1:0] w;
		logic [5:0] k;
		w = '0;
		for (int i = 0; i < 10; i++)
			if (i < KW_LEN && i < len) w[i*8 +: 8] = buf_in[i*8 +: 8];
		k = K_IDENT;
		if (len <= 16'(KW_LEN)) begin
			case (len)
				16'd2: begin
					if (w[15:0] == {"f", "i"}) k = 6'd24;
					else if (w[15:0] == {"n", "f"}) k = 6'd19;
				end
				16'd3: begin
					if (w[23:0] == {"t", "e", "l"}) k = 6'd30;
					else if (w[23:0] == {"r", "o", "f"}) k = 6'd20;
					else if (w[23:0] == {"t", "n", "I"}) k = 6'd25;
				end
				16'd4: begin
					if (w[31:0] == {"e", "s", "l", "e"}) k = 6'd14;
					else if (w[31:0] == {"l", "o", "o", "B"}) k = 6'd7;
					else if (w[31:0] == {"t", "i", "n", "U"}) k = 6'd50;
				end
				16'd5: if (w[39:0] == {"e", "l", "i", "h", "w"}) k = 6'd51;
				16'd6: begin
					if (w[47:0] == {"n", "r", "u", "t", "e", "r"}) k = 6'd44;
					else if (w[47:0] == {"t", "c", "u", "r", "t", "s"}) k = 6'd49;
					else if (w[47:0] == {"g", "n", "i", "r", "t", "S"}) k = 6'd47;
				end
				16'd10: if (w == {"y", "a", "r", "r", "A", "d", "e", "x", "i", "F"})
					k = 6'd18;
				default: k = K_IDENT;
			endcase
		end
		return k;
	endfunction

endpackage

/* hw/rtl/source_byte_tokenizer.sv */
// Channel | Signals                                          | Direction
// input   | valid_in/ready_in, byte_req, end_of_input         | in
// output  | valid_out/ready_out, kind, value, line, column,   | out
//         | length, error_code, last_of_run                   |
// One byte a cycle while ready_in is high: a byte's state update and up to four
// result beats are formed combinationally and written into an eight-entry result queue.
// A byte is taken whenever the queue has room for four beats, so bytes flow
// back to back while results drain; a beat with last_of_run closes each byte.
// A byte that yields no result is absorbed in its cycle.
// arst_n clears mode, counters and the queue; name bytes are not cleared.
module source_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [7:0]  byte_req,
	input  logic        end_of_input,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [5:0]  kind,
	output logic [31:0] value,
	output logic [15:0] line,
	output logic [15:0] column,
	output logic [15:0] length,
	output logic [2:0]  error_code,
	output logic        last_of_run
);
	import sbt_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	mode_t                   mode_q;
	logic [7:0]              pend_q;
	logic [KW_LEN*8-1:0]     kw_q;
	logic [15:0]             nlen_q;
	logic [31:0]             acc_q;
	logic                    ovf_q;
	logic [POS_BITS-1:0]     tl_q, tc_q, cl_q, cc_q;

	// Result queue: 8 entries, room for two bytes' worth
	tok_t       fifo_q [8];
	logic [7:0] flast_q;
	logic [2:0] rd_q, wr_q;
	logic [3:0] cnt_q;

	// Next-state and emitted beats
	mode_t               mode_d;
	logic [7:0]          pend_d;
	logic [KW_LEN*8-1:0] kw_d;
	logic [15:0]         nlen_d;
	logic [31:0]         acc_d;
	logic                ovf_d;
	logic [POS_BITS-1:0] tl_d, tc_d, cl_d, cc_d;
	tok_t                em [4];
	logic [2:0]          n_em;

	logic take, pop;
	assign ready_in = cnt_q <= 4'd4;
	assign take = valid_in && ready_in;
	assign valid_out = cnt_q != 4'd0;
	assign pop = valid_out && ready_out;

	always_comb begin
		logic [7:0] b;
		logic [POS_BITS-1:0] bl, bc;
		logic [15:0] tl16, tc16, bl16, bc16;
		logic do_start, bad;
		logic [5:0] k;
		logic [7:0] v;
		b = byte_req;
		bl = cl_q;
		bc = cc_q;
		bl16 = bl[15:0];
		bc16 = bc[15:0];
		mode_d = mode_q;
		pend_d = pend_q;
		kw_d = kw_q;
		nlen_d = nlen_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		tl_d = tl_q;
		tc_d = tc_q;
		n_em = '0;
		do_start = 1'b0;
		bad = 1'b0;
		k = K_NONE;
		v = 8'd0;
		for (int i = 0; i < 4; i++) em[i] = '0;
		tl16 = tl_q[15:0];
		tc16 = tc_q[15:0];

		// Continue the open token
		case (mode_q)
			M_NAME: begin
				if (is_alpha(b) || is_digit(b)) begin
					for (int i = 0; i < KW_LEN; i++)
						if (nlen_q == 16'(i)) kw_d[i*8 +: 8] = b;
					if (nlen_q != 16'hFFFF) nlen_d = nlen_q + 16'd1;
					em[0] = '{K_NAME_CHAR, {24'd0, b}, bl16, bc16, 16'd1, E_NONE};
					n_em = 3'd1;
				end else begin
					em[0] = '{kw_kind(kw_q, nlen_q), 32'd0, tl16, tc16, nlen_q, E_NONE};
					n_em = 3'd1;
					do_start = 1'b1;
				end
			end
			M_NUM: begin
				if (is_digit(b)) begin
					if (acc_q > OVF_LIMIT || (acc_q == OVF_LIMIT && b >= "8")) ovf_d = 1'b1;
					acc_d = acc_q * 32'd10 + {28'd0, 4'(b - "0")};
					if (nlen_q != 16'hFFFF) nlen_d = nlen_q + 16'd1;
				end else begin
					em[0] = '{K_INTLIT, acc_q, tl16, tc16, nlen_q,
						ovf_q ? E_OVERFLOW : E_NONE};
					n_em = 3'd1;
					do_start = 1'b1;
				end
			end
			M_STR: begin
				if (b == "\"") begin
					em[0] = '{K_STRLIT, 32'd0, tl16, tc16, nlen_q, E_NONE};
					n_em = 3'd1;
					mode_d = M_IDLE;
				end else if (b == "\\") begin
					mode_d = M_ESC;
				end else begin
					em[0] = '{K_STR_CHAR, {24'd0, b}, bl16, bc16, 16'd1, E_NONE};
					n_em = 3'd1;
					if (nlen_q != 16'hFFFF) nlen_d = nlen_q + 16'd1;
				end
			end
			M_ESC: begin
				case (b)
					"n": v = 8'd10;
					"t": v = 8'd9;
					"\"": v = 8'd34;
					"\\": v = 8'd92;
					"r": v = 8'd13;
					"b": v = 8'd8;
					"f": v = 8'd12;
					"v": v = 8'd11;
					default: begin
						v = b;
						bad = 1'b1;
					end
				endcase
				em[0] = '{K_STR_CHAR, {24'd0, v}, bl16, bc16, 16'd1,
					bad ? E_BAD_ESC : E_NONE};
				n_em = 3'd1;
				if (nlen_q != 16'hFFFF) nlen_d = nlen_q + 16'd1;
				mode_d = M_STR;
			end
			M_OP: begin
				k = pair_kind(pend_q, b);
				if (k != K_NONE) begin
					em[0] = '{k, 32'd0, tl16, tc16, 16'd2, E_NONE};
					n_em = 3'd1;
					mode_d = M_IDLE;
					pend_d = 8'd0;
				end else if (pend_q == "/" && b == "/") begin
					mode_d = M_CMT;
					pend_d = 8'd0;
				end else begin
					em[0] = '{single_kind(pend_q), 32'd0, tl16, tc16, 16'd1, E_NONE};
					n_em = 3'd1;
					do_start = 1'b1;
				end
			end
			M_CMT: if (b == 8'd10) mode_d = M_IDLE;
			default: do_start = 1'b1;
		endcase

		// Open a new token on this byte
		if (do_start) begin
			mode_d = M_IDLE;
			pend_d = 8'd0;
			if (!is_space(b)) begin
				tl_d = bl;
				tc_d = bc;
				tl16 = bl16;
				tc16 = bc16;
				if (is_alpha(b)) begin
					mode_d = M_NAME;
					kw_d[7:0] = b;
					nlen_d = 16'd1;
					em[n_em[1:0]] = '{K_NAME_CHAR, {24'd0, b}, bl16, bc16, 16'd1, E_NONE};
					n_em = n_em + 3'd1;
				end else if (is_digit(b)) begin
					mode_d = M_NUM;
					acc_d = {28'd0, 4'(b - "0")};
					ovf_d = 1'b0;
					nlen_d = 16'd1;
				end else if (b == "\"") begin
					mode_d = M_STR;
					nlen_d = 16'd0;
				end else if (is_prefix(b)) begin
					mode_d = M_OP;
					pend_d = b;
				end else if (single_kind(b) != K_NONE) begin
					em[n_em[1:0]] = '{single_kind(b), 32'd0, bl16, bc16, 16'd1, E_NONE};
					n_em = n_em + 3'd1;
				end else begin
					em[n_em[1:0]] = '{K_ERROR, {24'd0, b}, bl16, bc16, 16'd1, E_UNEXPECTED};
					n_em = n_em + 3'd1;
				end
			end
		end

		// Advance position
		if (b == 8'd10) begin
			cl_d = (cl_q != POS_MAX) ? cl_q + 1'b1 : cl_q;
			cc_d = POS_BITS'(1);
		end else begin
			cl_d = cl_q;
			cc_d = (cc_q != POS_MAX) ? cc_q + 1'b1 : cc_q;
		end

		// Flush and close the source
		if (end_of_input) begin
			case (mode_d)
				M_NAME: begin
					em[n_em[1:0]] = '{kw_kind(kw_d, nlen_d), 32'd0, tl16, tc16, nlen_d, E_NONE};
					n_em = n_em + 3'd1;
				end
				M_NUM: begin
					em[n_em[1:0]] = '{K_INTLIT, acc_d, tl16, tc16, nlen_d,
						ovf_d ? E_OVERFLOW : E_NONE};
					n_em = n_em + 3'd1;
				end
				M_ESC: begin
					em[n_em[1:0]] = '{K_STR_CHAR, 32'd92, bl16, bc16, 16'd1, E_ESC_EOI};
					n_em = n_em + 3'd1;
					em[n_em[1:0]] = '{K_STRLIT, 32'd0, tl16, tc16,
						(nlen_d != 16'hFFFF) ? nlen_d + 16'd1 : nlen_d, E_UNCLOSED};
					n_em = n_em + 3'd1;
				end
				M_STR: begin
					em[n_em[1:0]] = '{K_STRLIT, 32'd0, tl16, tc16, nlen_d, E_UNCLOSED};
					n_em = n_em + 3'd1;
				end
				M_OP: begin
					em[n_em[1:0]] = '{single_kind(pend_d), 32'd0, tl16, tc16, 16'd1, E_NONE};
					n_em = n_em + 3'd1;
				end
				default: ;
			endcase
			em[n_em[1:0]] = '{K_END, 32'd0, cl_d[15:0], cc_d[15:0], 16'd0, E_NONE};
			n_em = n_em + 3'd1;
			mode_d = M_IDLE;
			pend_d = 8'd0;
			nlen_d = 16'd0;
			acc_d = 32'd0;
			ovf_d = 1'b0;
			tl_d = POS_BITS'(1);
			tc_d = '0;
			cl_d = POS_BITS'(1);
			cc_d = '0;
		end
	end

	// Hold lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			nlen_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			tl_q <= POS_BITS'(1);
			tc_q <= '0;
			cl_q <= POS_BITS'(1);
			cc_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			nlen_q <= nlen_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			tl_q <= tl_d;
			tc_q <= tc_d;
			cl_q <= cl_d;
			cc_q <= cc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) kw_q <= kw_d;
	end

	// Push beats and pop on the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
			flast_q <= '0;
		end else begin
			if (take) begin
				for (int i = 0; i < 4; i++)
					if (3'(i) < n_em)
						flast_q[3'(wr_q + 3'(i))] <= (3'(i) == n_em - 3'd1);
				wr_q <= wr_q + n_em;
			end
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + (take ? {1'b0, n_em} : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			for (int i = 0; i < 4; i++)
				if (3'(i) < n_em) fifo_q[3'(wr_q + 3'(i))] <= em[i];
	end

	assign kind = fifo_q[rd_q].kind;
	assign value = fifo_q[rd_q].value;
	assign line = fifo_q[rd_q].line;
	assign column = fifo_q[rd_q].column;
	assign length = fifo_q[rd_q].length;
	assign error_code = fifo_q[rd_q].error_code;
	assign last_of_run = flast_q[rd_q];

endmodule
